/* design/rpcf_pkg.sv */
package rpcf_pkg;

   // filter selector codes, values 5 to 7 pass the pixel through
   typedef enum logic [2:0] {
      MODE_DROP_RED   = 3'd0,
      MODE_DROP_GREEN = 3'd1,
      MODE_DROP_BLUE  = 3'd2,
      MODE_GRAY       = 3'd3,
      MODE_SEPIA      = 3'd4
   } mode_type;

   typedef enum logic [0:0] {
      CSR_FILTER_MODE = 1'b0,
      CSR_MAX_VALUE   = 1'b1
   } csr_index_type;

   localparam int MODE_BITS = 3;
   localparam int MAXV_BITS = 16;
   localparam int COEF_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int PIX_BITS  = 16;

   localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_GRAY;
   localparam logic [MAXV_BITS-1:0] MAXV_RESET = 16'd255;

   typedef logic [COEF_BITS-1:0] coef_type;

   // unsigned q0.16 weights, row per output channel
   localparam coef_type SEPIA_W [3][3] = '{
      '{16'd25756, 16'd50397, 16'd12386},
      '{16'd22872, 16'd44958, 16'd11010},
      '{16'd17826, 16'd34996, 16'd8585}
   };

   localparam coef_type GRAY_W [3] = '{16'd19661, 16'd38666, 16'd7209};

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [MAXV_BITS-1:0] max_value;
   } cfg_type;

endpackage

/* design/rpcf_csr.sv */
module rpcf_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [15:0]           csr_data,
   output rpcf_pkg::cfg_type     cfg
);
   import rpcf_pkg::*;

   logic [MODE_BITS-1:0] mode_ff;
   logic [MAXV_BITS-1:0] maxv_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         maxv_ff <= MAXV_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_MODE: mode_ff <= csr_data[MODE_BITS-1:0];
            CSR_MAX_VALUE:   maxv_ff <= csr_data[MAXV_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.mode      = mode_ff;
   assign cfg.max_value = maxv_ff;

endmodule

/* design/rpcf_mul.sv */
module rpcf_mul #(
   parameter int COLOR_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [COLOR_BITS-1:0]              in_ch [3],
   input  logic                               in_last,
   input  logic [rpcf_pkg::MODE_BITS-1:0]     in_mode,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [COLOR_BITS+15:0]             out_prod [3][3],
   output logic [COLOR_BITS-1:0]              out_ch [3],
   output logic [rpcf_pkg::MODE_BITS-1:0]     out_mode,
   output logic                               out_last
);
   import rpcf_pkg::*;

   localparam int PW = COLOR_BITS + COEF_BITS;

   // stage 1: input register
   logic                  v1_ff, v1_in;
   logic [COLOR_BITS-1:0] ch1_ff [3];
   logic [MODE_BITS-1:0]  mode1_ff;
   logic                  last1_ff;

   // stage 2: product register
   logic                  v2_ff, v2_in;
   logic [PW-1:0]         prod2_ff [3][3];
   logic [PW-1:0]         prod2_in [3][3];
   logic [COLOR_BITS-1:0] ch2_ff [3];
   logic [MODE_BITS-1:0]  mode2_ff;
   logic                  last2_ff;

   logic ready1, ready2;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   assign v1_in = ready1 ? in_valid : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;

   // row 0 carries the grey weights in grey mode, the sepia rows otherwise
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (mode1_ff == MODE_GRAY && k == 0)
               prod2_in[k][i] = PW'(ch1_ff[i]) * PW'(GRAY_W[i]);
            else
               prod2_in[k][i] = PW'(ch1_ff[i]) * PW'(SEPIA_W[k][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready1) begin
         ch1_ff   <= in_ch;
         mode1_ff <= in_mode;
         last1_ff <= in_last;
      end
      if (v1_ff && ready2) begin
         prod2_ff <= prod2_in;
         ch2_ff   <= ch1_ff;
         mode2_ff <= mode1_ff;
         last2_ff <= last1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_prod  = prod2_ff;
   assign out_ch    = ch2_ff;
   assign out_mode  = mode2_ff;
   assign out_last  = last2_ff;

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && v1_ff && !ready2) |-> v1_ff && $stable(last1_ff))
      else $error("stage 1 dropped a stalled pixel");

   a_stage2_fill: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && v1_ff && ready2) |-> v2_ff)
      else $error("pixel leaving stage 1 did not reach stage 2");

endmodule

/* design/rpcf_mix.sv */
module rpcf_mix #(
   parameter int COLOR_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [COLOR_BITS+15:0]             in_prod [3][3],
   input  logic [COLOR_BITS-1:0]              in_ch [3],
   input  logic [rpcf_pkg::MODE_BITS-1:0]     in_mode,
   input  logic                               in_last,
   input  logic [rpcf_pkg::MAXV_BITS-1:0]     max_value,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [rpcf_pkg::PIX_BITS-1:0]      out_pix [3],
   output logic                               out_clipped,
   output logic                               out_last
);
   import rpcf_pkg::*;

   localparam int PW = COLOR_BITS + COEF_BITS;
   localparam int SW = PW + 2;
   localparam int VW = COLOR_BITS + 2;

   // stage 3: channel sums
   logic                  v3_ff, v3_in;
   logic [VW-1:0]         val3_ff [3];
   logic [VW-1:0]         val3_in [3];
   logic [COLOR_BITS-1:0] ch3_ff [3];
   logic [MODE_BITS-1:0]  mode3_ff;
   logic                  last3_ff;

   // stage 4: saturation and output register
   logic                  v4_ff, v4_in;
   logic [PIX_BITS-1:0]   pix4_ff [3];
   logic [PIX_BITS-1:0]   pix4_in [3];
   logic                  clip4_ff, clip4_in;
   logic                  last4_ff;

   logic          ready3, ready4;
   logic [SW-1:0] sep_sum [3];
   logic [VW-1:0] gray_sum;
   logic [31:0]   wide;
   logic [31:0]   maxw;

   assign ready4   = !v4_ff || out_ready;
   assign ready3   = !v3_ff || ready4;
   assign in_ready = ready3;

   assign v3_in = ready3 ? in_valid : v3_ff;
   assign v4_in = ready4 ? v3_ff : v4_ff;

   // grey terms are truncated one by one, sepia rows once after the sum
   always_comb begin
      gray_sum = VW'(in_prod[0][0][PW-1:FRAC_BITS])
               + VW'(in_prod[0][1][PW-1:FRAC_BITS])
               + VW'(in_prod[0][2][PW-1:FRAC_BITS]);
      for (int k = 0; k < 3; k++) begin
         sep_sum[k] = SW'(in_prod[k][0]) + SW'(in_prod[k][1]) + SW'(in_prod[k][2]);
         if (in_mode == MODE_GRAY)
            val3_in[k] = gray_sum;
         else
            val3_in[k] = sep_sum[k][SW-1:FRAC_BITS];
      end
   end

   always_comb begin
      maxw     = 32'(max_value);
      clip4_in = 1'b0;
      wide     = '0;
      for (int k = 0; k < 3; k++)
         pix4_in[k] = PIX_BITS'(32'(ch3_ff[k]));
      case (mode3_ff)
         MODE_DROP_RED:   pix4_in[0] = '0;
         MODE_DROP_GREEN: pix4_in[1] = '0;
         MODE_DROP_BLUE:  pix4_in[2] = '0;
         MODE_GRAY: begin
            for (int k = 0; k < 3; k++) begin
               wide       = 32'(val3_ff[k]);
               pix4_in[k] = wide[PIX_BITS-1:0];
            end
         end
         MODE_SEPIA: begin
            for (int k = 0; k < 3; k++) begin
               wide = 32'(val3_ff[k]);
               if (wide > maxw) begin
                  wide     = maxw;
                  clip4_in = 1'b1;
               end
               pix4_in[k] = wide[PIX_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready3) begin
         val3_ff  <= val3_in;
         ch3_ff   <= in_ch;
         mode3_ff <= in_mode;
         last3_ff <= in_last;
      end
      if (v3_ff && ready4) begin
         pix4_ff  <= pix4_in;
         clip4_ff <= clip4_in;
         last4_ff <= last3_ff;
      end
   end

   assign out_valid   = v4_ff;
   assign out_pix     = pix4_ff;
   assign out_clipped = clip4_ff;
   assign out_last    = last4_ff;

   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && v3_ff && !ready4) |->
         v3_ff && $stable(val3_ff[0]) && $stable(val3_ff[1]) && $stable(val3_ff[2]))
      else $error("stage 3 changed while stalled");

   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      v3_ff && mode3_ff == MODE_GRAY |->
         val3_ff[1] == val3_ff[0] && val3_ff[2] == val3_ff[0])
      else $error("grey sums differ between channels");

endmodule

/* design/rgb_pixel_color_filter_core.sv */
// Pixel colour filter: one rgb pixel in, one filtered pixel out, one pixel per clock
// sustained unless rsp back-pressure stalls it. The mode register picks drop red, drop
// green, drop blue, grayscale or sepia (codes 5 to 7 pass the pixel through); sepia
// saturates at max_value and sets the clip flag in rsp_tuser. Each pixel passes
// through the four register stages: input, weight products, channel sums, saturation
// and output. Back-pressure stalls the stages without losing data, and bubbles are
// squeezed out. Only the low COLOR_BITS bits of each input channel are used.
// Configuration writes are accepted every cycle and should be made while no pixel
// is in flight.
module rgb_pixel_color_filter_core #(
   parameter int COLOR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red_out, green_out, blue_out
   output logic [0:0]  rsp_tuser,   // clipped
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rpcf_pkg::*;

   cfg_type               cfg;
   logic [COLOR_BITS-1:0] in_ch [3];
   logic                  mid_valid, mid_ready;
   logic [COLOR_BITS+15:0] mid_prod [3][3];
   logic [COLOR_BITS-1:0] mid_ch [3];
   logic [MODE_BITS-1:0]  mid_mode;
   logic                  mid_last;
   logic [PIX_BITS-1:0]   out_pix [3];

   assign in_ch[0] = req_tdata[COLOR_BITS-1:0];
   assign in_ch[1] = req_tdata[PIX_BITS+COLOR_BITS-1:PIX_BITS];
   assign in_ch[2] = req_tdata[2*PIX_BITS+COLOR_BITS-1:2*PIX_BITS];

   rpcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rpcf_mul #(.COLOR_BITS(COLOR_BITS)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ch     (in_ch),
      .in_last   (req_tlast),
      .in_mode   (cfg.mode),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_prod  (mid_prod),
      .out_ch    (mid_ch),
      .out_mode  (mid_mode),
      .out_last  (mid_last)
   );

   rpcf_mix #(.COLOR_BITS(COLOR_BITS)) u_mix (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .in_prod     (mid_prod),
      .in_ch       (mid_ch),
      .in_mode     (mid_mode),
      .in_last     (mid_last),
      .max_value   (cfg.max_value),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pix     (out_pix),
      .out_clipped (rsp_tuser[0]),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {out_pix[2], out_pix[1], out_pix[0]};

endmodule
